/* design/bgfa_pkg.sv */
package bgfa_pkg;

    // Widths of the time stamp and of the configuration registers.
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned ADDR_W = 3;

    // Configuration register indexes.
    typedef enum logic [ADDR_W-1:0] {
        REG_GLITCH_HOLD   = 3'd0,
        REG_BASE_REPEAT   = 3'd1,
        REG_MEDIUM_REPEAT = 3'd2,
        REG_FAST_REPEAT   = 3'd3,
        REG_MEDIUM_HOLD   = 3'd4,
        REG_FAST_HOLD     = 3'd5
    } reg_index_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] GLITCH_HOLD_RST   = 16'd30;
    localparam logic [CFG_W-1:0] BASE_REPEAT_RST   = 16'd200;
    localparam logic [CFG_W-1:0] MEDIUM_REPEAT_RST = 16'd70;
    localparam logic [CFG_W-1:0] FAST_REPEAT_RST   = 16'd40;
    localparam logic [CFG_W-1:0] MEDIUM_HOLD_RST   = 16'd3000;
    localparam logic [CFG_W-1:0] FAST_HOLD_RST     = 16'd6000;

    // Input beat.
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              raw_up;
        logic              raw_down;
    } in_beat_t;

    // Output beat.
    typedef struct packed {
        logic step_up;
        logic step_down;
        logic up_level;
        logic down_level;
    } out_beat_t;

    // Configuration settings as seen by the button logic.
    typedef struct packed {
        logic [CFG_W-1:0] glitch_hold_ms;
        logic [CFG_W-1:0] base_repeat_ms;
        logic [CFG_W-1:0] medium_repeat_ms;
        logic [CFG_W-1:0] fast_repeat_ms;
        logic [CFG_W-1:0] medium_hold_ms;
        logic [CFG_W-1:0] fast_hold_ms;
    } cfg_t;

    // State kept for one button.
    typedef struct packed {
        logic              raw_seen;
        logic [TIME_W-1:0] raw_change_time;
        logic              filtered;
        logic              held_flag;
        logic [TIME_W-1:0] press_start_time;
        logic [TIME_W-1:0] last_step_time;
    } btn_state_t;

    // Next state of one button plus its step pulse.
    typedef struct packed {
        btn_state_t state;
        logic       step;
    } btn_result_t;

    // Glitch filter and accelerating repeat for one button on one beat.
    function automatic btn_result_t btn_update(
        input btn_state_t        cur,
        input logic [TIME_W-1:0] now,
        input logic              raw,
        input cfg_t              cfg
    );
        btn_result_t       res;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] hold;
        logic [TIME_W-1:0] since_step;
        logic [CFG_W-1:0]  interval;

        res.state    = cur;
        res.step     = 1'b0;
        since_change = now - cur.raw_change_time;

        // A raw change restarts the hold timer; a steady level passes once held long enough.
        if (raw != cur.raw_seen)
        begin
            res.state.raw_seen        = raw;
            res.state.raw_change_time = now;
        end
        else if ((raw != cur.filtered) &&
                 (since_change >= {{(TIME_W-CFG_W){1'b0}}, cfg.glitch_hold_ms}))
        begin
            res.state.filtered = raw;
        end

        // Mark the start of a press on the first beat the filtered level is high.
        if (res.state.filtered && !cur.held_flag)
        begin
            res.state.press_start_time = now;
            res.state.held_flag        = 1'b1;
        end
        if (!res.state.filtered)
        begin
            res.state.held_flag = 1'b0;
        end

        hold       = now - res.state.press_start_time;
        since_step = now - cur.last_step_time;

        // The long hold threshold is tested first.
        if (hold > {{(TIME_W-CFG_W){1'b0}}, cfg.fast_hold_ms})
        begin
            interval = cfg.fast_repeat_ms;
        end
        else if (hold > {{(TIME_W-CFG_W){1'b0}}, cfg.medium_hold_ms})
        begin
            interval = cfg.medium_repeat_ms;
        end
        else
        begin
            interval = cfg.base_repeat_ms;
        end

        if (res.state.filtered && (since_step > {{(TIME_W-CFG_W){1'b0}}, interval}))
        begin
            res.state.last_step_time = now;
            res.step                 = 1'b1;
        end

        return res;
    endfunction

endpackage

/* design/button_glitch_filter_autorepeat.sv */
// Two-button glitch filter with accelerating auto-repeat.
//
// Input channel (in_valid/in_ready/in_data): one beat per sample, carrying a
// free-running millisecond time stamp and the raw up and down button levels.
// Output channel (out_valid/out_ready/out_data): exactly one beat per input
// beat, with a step pulse for each button and the filtered button levels.
// Configuration: six 16-bit registers written through cfg_en/cfg_addr/cfg_data;
// writes to unused indexes are dropped. Write them only
// while no beat is in flight.
//
// The beat is held in the input register, then the filter and repeat logic
// loads the output register, which drives out_valid. Throughput is one beat
// per cycle while the receiver does not stall; the button state updates as
// each beat moves into the output register.
// When the receiver stalls, the output beat holds and the input register
// still takes one more beat; after that in_ready drops until out_ready returns.
// Reset clears all button state to zero (filters low, timers at zero), loads
// the configuration defaults and empties both registers.
module button_glitch_filter_autorepeat (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  bgfa_pkg::in_beat_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output bgfa_pkg::out_beat_t              out_data,
    input  logic                             cfg_en,
    input  logic [bgfa_pkg::ADDR_W-1:0]      cfg_addr,
    input  logic [bgfa_pkg::CFG_W-1:0]       cfg_data
);
    import bgfa_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    in_beat_t    in_data_reg;
    logic        out_valid_reg;
    out_beat_t   out_data_reg;
    btn_state_t  up_reg;
    btn_state_t  down_reg;
    btn_result_t up_next;
    btn_result_t down_next;
    logic        advance;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glitch_hold_ms   <= GLITCH_HOLD_RST;
            cfg_reg.base_repeat_ms   <= BASE_REPEAT_RST;
            cfg_reg.medium_repeat_ms <= MEDIUM_REPEAT_RST;
            cfg_reg.fast_repeat_ms   <= FAST_REPEAT_RST;
            cfg_reg.medium_hold_ms   <= MEDIUM_HOLD_RST;
            cfg_reg.fast_hold_ms     <= FAST_HOLD_RST;
        end
        else if (cfg_en)
        begin
            unique case (cfg_addr)
                REG_GLITCH_HOLD:   cfg_reg.glitch_hold_ms   <= cfg_data;
                REG_BASE_REPEAT:   cfg_reg.base_repeat_ms   <= cfg_data;
                REG_MEDIUM_REPEAT: cfg_reg.medium_repeat_ms <= cfg_data;
                REG_FAST_REPEAT:   cfg_reg.fast_repeat_ms   <= cfg_data;
                REG_MEDIUM_HOLD:   cfg_reg.medium_hold_ms   <= cfg_data;
                REG_FAST_HOLD:     cfg_reg.fast_hold_ms     <= cfg_data;
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // The input register moves on whenever the output register is free or being drained.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // Button logic; the up button and the down button see the same time stamp.
    always_comb
    begin
        up_next   = btn_update(up_reg, in_data_reg.now_ms, in_data_reg.raw_up, cfg_reg);
        down_next = btn_update(down_reg, in_data_reg.now_ms, in_data_reg.raw_down, cfg_reg);
    end

    // Button state commits when the beat moves into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= '0;
            down_reg <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            up_reg   <= up_next.state;
            down_reg <= down_next.state;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
        begin
            out_data_reg.step_up    <= up_next.step;
            out_data_reg.step_down  <= down_next.step;
            out_data_reg.up_level   <= up_next.state.filtered;
            out_data_reg.down_level <= down_next.state.filtered;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/bgfa_checker.sv */
module bgfa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input bgfa_pkg::in_beat_t          in_data,
    input logic                        out_valid,
    input logic                        out_ready,
    input bgfa_pkg::out_beat_t         out_data
);
    import bgfa_pkg::*;

    // A stalled output beat must hold its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // An up step only fires while the filtered up level is high.
    a_up_step_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.step_up || out_data.up_level))
        else $error("up step without filtered up level");

    // A down step only fires while the filtered down level is high.
    a_down_step_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.step_down || out_data.down_level))
        else $error("down step without filtered down level");

    // An accepted beat reaches the output when out_ready lets it leave the input register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind button_glitch_filter_autorepeat bgfa_checker u_bgfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* sim/tb_button_glitch_filter_autorepeat.sv */
module tb_button_glitch_filter_autorepeat;

    import bgfa_pkg::*;

    // Run length guard and the register indexes that do not exist.
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam logic [ADDR_W-1:0] UNUSED_REG_LO = 3'd6;
    localparam logic [ADDR_W-1:0] UNUSED_REG_HI = 3'd7;

    // State the predictor keeps for one button.
    typedef struct {
        logic        seen;
        logic [31:0] change_at;
        logic        level;
        logic        pressed;
        logic [31:0] press_at;
        logic [31:0] last_step_at;
    } key_state_t;

    localparam int unsigned KEY_UP = 0;
    localparam int unsigned KEY_DOWN = 1;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_beat_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_beat_t           out_data;
    logic                cfg_en;
    logic [ADDR_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]    cfg_data;

    // Predictor state, shadow settings and the outputs still owed by the block.
    key_state_t          keys [2];
    cfg_t                active_cfg;
    out_beat_t           step_forecast [$];

    int unsigned         mismatch_count;
    int unsigned         cycle_count;
    int unsigned         idle_pct;
    int unsigned         stall_pct;
    int unsigned         hold_request;
    int unsigned         stall_left;
    logic [31:0]         stamp_ms;
    logic                up_intent;
    logic                down_intent;

    button_glitch_filter_autorepeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_en    (cfg_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_button_glitch_filter_autorepeat: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    always @(negedge clk)
    begin
        if (stall_left == 0 && hold_request != 0)
        begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // One button of the filter and repeat logic, advanced by one sample.
    function automatic logic key_advance(int unsigned which, logic [31:0] now, logic raw);
        key_state_t  k;
        logic [31:0] since_change;
        logic [31:0] held_for;
        logic [31:0] since_step;
        logic [31:0] interval;
        logic        fired;

        k = keys[which];
        fired = 1'b0;
        since_change = now - k.change_at;

        if (raw != k.seen)
        begin
            k.seen = raw;
            k.change_at = now;
        end
        else if (raw != k.level && since_change >= {16'd0, active_cfg.glitch_hold_ms})
        begin
            k.level = raw;
        end

        if (k.level && !k.pressed)
        begin
            k.press_at = now;
            k.pressed = 1'b1;
        end
        if (!k.level)
        begin
            k.pressed = 1'b0;
        end

        // The long hold wins wherever both thresholds are passed.
        if (k.level)
        begin
            held_for = now - k.press_at;
            if (held_for > {16'd0, active_cfg.fast_hold_ms})
                interval = {16'd0, active_cfg.fast_repeat_ms};
            else if (held_for > {16'd0, active_cfg.medium_hold_ms})
                interval = {16'd0, active_cfg.medium_repeat_ms};
            else
                interval = {16'd0, active_cfg.base_repeat_ms};
            since_step = now - k.last_step_at;
            if (since_step > interval)
            begin
                k.last_step_at = now;
                fired = 1'b1;
            end
        end

        keys[which] = k;
        return fired;
    endfunction

    // Expected output beat for one input beat; up is handled before down.
    function automatic out_beat_t predict_buttons(in_beat_t beat);
        out_beat_t res;

        res.step_up = key_advance(KEY_UP, beat.now_ms, beat.raw_up);
        res.step_down = key_advance(KEY_DOWN, beat.now_ms, beat.raw_down);
        res.up_level = keys[KEY_UP].level;
        res.down_level = keys[KEY_DOWN].level;
        return res;
    endfunction

    task automatic report_field(string name, logic want, logic got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0b, got %0b", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Output checker: every accepted beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        out_beat_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (step_forecast.size() == 0)
            begin
                $display("%0t: unexpected output beat, expected none, got %b", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = step_forecast.pop_front();
                report_field("step_up", want.step_up, out_data.step_up);
                report_field("step_down", want.step_down, out_data.step_down);
                report_field("up_level", want.up_level, out_data.up_level);
                report_field("down_level", want.down_level, out_data.down_level);
            end
        end
    end

    // Offer one sample after an optional random gap and wait for the handshake.
    task automatic send_beat(logic [31:0] now, logic up, logic down);
        in_beat_t beat;

        beat.now_ms = now;
        beat.raw_up = up;
        beat.raw_down = down;
        stamp_ms = now;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        step_forecast.push_back(predict_buttons(beat));
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted beat has come out.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (step_forecast.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write; the predictor follows it, and unused indexes change nothing.
    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
        cfg_en <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        case (addr)
            REG_GLITCH_HOLD:   active_cfg.glitch_hold_ms = value;
            REG_BASE_REPEAT:   active_cfg.base_repeat_ms = value;
            REG_MEDIUM_REPEAT: active_cfg.medium_repeat_ms = value;
            REG_FAST_REPEAT:   active_cfg.fast_repeat_ms = value;
            REG_MEDIUM_HOLD:   active_cfg.medium_hold_ms = value;
            REG_FAST_HOLD:     active_cfg.fast_hold_ms = value;
            default:           ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_settings(cfg_t s, bit with_unused);
        write_reg(REG_GLITCH_HOLD, s.glitch_hold_ms);
        write_reg(REG_BASE_REPEAT, s.base_repeat_ms);
        write_reg(REG_MEDIUM_REPEAT, s.medium_repeat_ms);
        write_reg(REG_FAST_REPEAT, s.fast_repeat_ms);
        write_reg(REG_MEDIUM_HOLD, s.medium_hold_ms);
        write_reg(REG_FAST_HOLD, s.fast_hold_ms);
        if (with_unused)
        begin
            write_reg(UNUSED_REG_LO, CFG_W'($urandom()));
            write_reg(UNUSED_REG_HI, CFG_W'($urandom()));
        end
        cfg_en <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly short values so holds reach both thresholds; now and then an extreme.
    function automatic logic [CFG_W-1:0] pick_ms(int unsigned hi);
        int unsigned roll;

        roll = $urandom_range(39);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return CFG_W'($urandom_range(hi));
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;

        s.glitch_hold_ms = pick_ms(10);
        s.base_repeat_ms = pick_ms(40);
        s.medium_repeat_ms = pick_ms(20);
        s.fast_repeat_ms = pick_ms(8);
        s.medium_hold_ms = pick_ms(300);
        s.fast_hold_ms = pick_ms(600);
        return s;
    endfunction

    // Button presses with bounce, long holds and time running forward; a few
    // samples jump to random times or to just before the counter wraps.
    task automatic run_sessions(int unsigned count, int unsigned max_dt);
        int unsigned roll;
        logic [31:0] now;
        logic        up;
        logic        down;

        for (int unsigned i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                now = $urandom();
            else if (roll < 6)
                now = 32'hFFFF_FFFF - $urandom_range(60);
            else
                now = stamp_ms + $urandom_range(max_dt);
            if ($urandom_range(99) < 3)
                up_intent = ~up_intent;
            if ($urandom_range(99) < 3)
                down_intent = ~down_intent;
            up = up_intent ^ ($urandom_range(99) < 6);
            down = down_intent ^ ($urandom_range(99) < 6);
            send_beat(now, up, down);
        end
    endtask

    // Defaults after reset: pins already pressed, first steps, a bounce, time wrap.
    task automatic test_reset_behavior();
        send_beat(32'd5, 1'b1, 1'b0);
        send_beat(32'd20, 1'b1, 1'b1);
        send_beat(32'd35, 1'b1, 1'b1);
        send_beat(32'd201, 1'b1, 1'b1);
        send_beat(32'd202, 1'b0, 1'b1);
        send_beat(32'd203, 1'b1, 1'b1);
        send_beat(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_beat(32'h0000_0010, 1'b0, 1'b0);
        send_beat(32'h0000_0040, 1'b0, 1'b0);
        wait_drain();
    endtask

    // With no hold time a change passes on the next sample at the same level.
    task automatic test_zero_glitch_hold();
        cfg_t s;

        s = active_cfg;
        s.glitch_hold_ms = '0;
        s.base_repeat_ms = '0;
        load_settings(s, 1'b0);
        send_beat(32'd1000, 1'b1, 1'b0);
        send_beat(32'd1000, 1'b1, 1'b0);
        send_beat(32'd1001, 1'b1, 1'b1);
        send_beat(32'd1001, 1'b1, 1'b1);
        wait_drain();
    endtask

    // Long hold threshold below the medium one: the fast interval takes over.
    task automatic test_threshold_order();
        cfg_t s;

        s.glitch_hold_ms = 16'd1;
        s.base_repeat_ms = 16'd20;
        s.medium_repeat_ms = 16'd5;
        s.fast_repeat_ms = 16'd2;
        s.medium_hold_ms = 16'd50;
        s.fast_hold_ms = 16'd10;
        load_settings(s, 1'b0);
        send_beat(32'd3000, 1'b0, 1'b0);
        send_beat(32'd3001, 1'b1, 1'b0);
        send_beat(32'd3002, 1'b1, 1'b0);
        for (int unsigned i = 1; i <= 5; i++)
            send_beat(32'd3002 + 4 * i, 1'b1, 1'b0);
        wait_drain();
    endtask

    // Every register at its top value, then at zero; unused indexes are poked too.
    task automatic test_register_extremes();
        cfg_t        s;
        logic [31:0] base;

        s = '1;
        load_settings(s, 1'b1);
        base = stamp_ms + 32'd100;
        send_beat(base, 1'b1, 1'b1);
        send_beat(base + 32'd65534, 1'b1, 1'b1);
        send_beat(base + 32'd65535, 1'b1, 1'b1);
        wait_drain();
        s = '0;
        load_settings(s, 1'b1);
        send_beat(base + 32'd70000, 1'b0, 1'b1);
        send_beat(base + 32'd70000, 1'b0, 1'b1);
        wait_drain();
    endtask

    // Random sessions under each mix of sender gaps and receiver stalls.
    task automatic test_random_traffic();
        int unsigned idle_mix [4];
        int unsigned stall_mix [4];

        idle_mix = '{0, 53, 0, 6};
        stall_mix = '{0, 0, 53, 6};
        for (int unsigned p = 0; p < 4; p++)
        begin
            wait_drain();
            idle_pct = idle_mix[p];
            stall_pct = stall_mix[p];
            load_settings(random_settings(), p == 0);
            run_sessions(300, $urandom_range(1, 12));
        end
        wait_drain();
    endtask

    // The receiver holds off for a long stretch while samples keep coming.
    task automatic test_output_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        load_settings(random_settings(), 1'b0);
        hold_request = 150;
        run_sessions(60, 6);
        wait_drain();
    endtask

    // The sender stops until every beat is out, then resumes with the same state.
    task automatic test_sender_pause();
        idle_pct = 6;
        stall_pct = 6;
        load_settings(random_settings(), 1'b0);
        run_sessions(40, 8);
        wait_drain();
        run_sessions(40, 8);
        wait_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_en = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 0;
        stall_left = 0;
        stamp_ms = '0;
        up_intent = 1'b0;
        down_intent = 1'b0;
        for (int unsigned k = 0; k < 2; k++)
            keys[k] = '{1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0};
        active_cfg.glitch_hold_ms = GLITCH_HOLD_RST;
        active_cfg.base_repeat_ms = BASE_REPEAT_RST;
        active_cfg.medium_repeat_ms = MEDIUM_REPEAT_RST;
        active_cfg.fast_repeat_ms = FAST_REPEAT_RST;
        active_cfg.medium_hold_ms = MEDIUM_HOLD_RST;
        active_cfg.fast_hold_ms = FAST_HOLD_RST;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_behavior();
        test_zero_glitch_hold();
        test_threshold_order();
        test_register_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && step_forecast.size() == 0)
            $display("tb_button_glitch_filter_autorepeat: done, clean");
        else
            $display("tb_button_glitch_filter_autorepeat: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
design/bgfa_pkg.sv
design/button_glitch_filter_autorepeat.sv
design/bgfa_checker.sv
sim/tb_button_glitch_filter_autorepeat.sv
